>>> rtl/tbgd_pkg.sv
// Package for the two-button gesture decoder: time widths, register indexes,
// event codes, gesture state type and saturating timer helpers.
// Depends on nothing.
`default_nettype none

package tbgd_pkg;

    // Width of the internal millisecond timers.
    localparam int TIME_W = 16;
    // Width of the elapsed field and of the configuration registers.
    localparam int EL_W   = 16;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 8;
    // Wide enough for a timer plus an elapsed value without wrapping.
    localparam int SUM_W  = ((TIME_W > EL_W) ? TIME_W : EL_W) + 1;
    localparam logic [SUM_W-1:0] TIME_MAX = SUM_W'((64'd1 << TIME_W) - 64'd1);

    typedef logic [TIME_W-1:0] time_t;
    typedef logic [EL_W-1:0]   elapsed_t;
    typedef logic [CFG_W-1:0]  cfg_t;
    typedef logic [IDX_W-1:0]  cfg_index_t;

    localparam cfg_index_t REG_RELEASE_TIME = 8'd0;
    localparam cfg_index_t REG_PAIR_WINDOW  = 8'd1;
    localparam cfg_index_t REG_LONG_TIME    = 8'd2;
    localparam cfg_index_t REG_CHORD_TIME   = 8'd3;

    localparam cfg_t RELEASE_TIME_RST = 16'd100;
    localparam cfg_t PAIR_WINDOW_RST  = 16'd100;
    localparam cfg_t LONG_TIME_RST    = 16'd600;
    localparam cfg_t CHORD_TIME_RST   = 16'd2000;

    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_FIRST_SHORT  = 3'd1,
        EV_SECOND_SHORT = 3'd2,
        EV_FIRST_LONG   = 3'd3,
        EV_SECOND_LONG  = 3'd4,
        EV_SLEEP        = 3'd5
    } event_t;

    // Everything that ending a gesture clears; arming lives outside it.
    typedef struct packed {
        logic  in_chord;
        logic  suppressing;
        logic  chord_armed;
        logic  long_reported;
        logic  prev_first;
        logic  prev_second;
        time_t release_timer;
        time_t since_first_timer;
        time_t hold_timer;
    } gesture_t;

    // Timer plus elapsed time, held at the timer's maximum on overflow.
    function automatic time_t sat_add(input time_t t, input elapsed_t el);
        logic [SUM_W-1:0] s;
        s = SUM_W'(t) + SUM_W'(el);
        if (s > TIME_MAX) begin
            s = TIME_MAX;
        end
        return TIME_W'(s);
    endfunction

    function automatic logic time_ge(input time_t t, input cfg_t c);
        return SUM_W'(t) >= SUM_W'(c);
    endfunction

    function automatic logic time_le(input time_t t, input cfg_t c);
        return SUM_W'(t) <= SUM_W'(c);
    endfunction

endpackage

`default_nettype wire

>>> rtl/two_button_gesture_decoder.sv
// Top level of the two-button gesture decoder: input register, decode logic,
// gesture state, configuration registers and result register.
// Depends on tbgd_pkg.
//
// Usage. Each input beat is one sample of the two button levels together with
// the milliseconds elapsed since the previous sample. Every input beat yields
// exactly one output beat carrying an event code (none, short or long press of
// either button, or the sleep chord), in the order the samples arrived.
// The input beat is captured in an input register; once the result register
// can take a beat, the decode logic combines it with the gesture state,
// updates that state and loads the result register. While out_stall is low
// the block sustains one beat per cycle in both directions, with a single
// pass of add, saturate and compare through each timer between the two
// registers.
// When the receiver raises out_stall the result register holds its beat and
// the input register holds its sample; in_stall rises only while both are
// occupied, so a stall costs no throughput once it is lifted.
// Configuration writes on the cfg channel are always ready and take effect
// at once; they are meant to be made while no sample is in flight.
// Reset clears the pipeline and the gesture state and loads the default
// thresholds; the block then stays disarmed, reporting no events, until both
// buttons have been seen released for release_time milliseconds.
`default_nettype none

module two_button_gesture_decoder (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 first_button,
    input  wire logic                 second_button,
    input  wire tbgd_pkg::elapsed_t   elapsed,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [2:0]                event_code,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire tbgd_pkg::cfg_index_t cfg_index,
    input  wire tbgd_pkg::cfg_t       cfg_data
);

    import tbgd_pkg::*;

    // Input register.
    logic     s1_valid_reg;
    logic     s1_first_reg;
    logic     s1_second_reg;
    elapsed_t s1_elapsed_reg;

    // Result register.
    logic     out_valid_reg;
    event_t   event_reg;

    // Gesture state.
    logic     armed_reg;
    logic     armed_next;
    gesture_t gest_reg;
    gesture_t gest_next;
    event_t   event_next;

    // Configuration registers.
    cfg_t release_time_reg;
    cfg_t pair_window_reg;
    cfg_t long_time_reg;
    cfg_t chord_time_reg;

    logic advance;
    logic s1_fire;
    logic was_first;
    logic was_second;

    // The result register can take a new beat when it is empty or being read.
    assign advance   = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && advance;
    assign in_stall  = s1_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign event_code = event_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // The sample payload needs no reset; it is only used with its valid bit.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_first_reg   <= first_button;
            s1_second_reg  <= second_button;
            s1_elapsed_reg <= elapsed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            event_reg     <= EV_NONE;
            armed_reg     <= 1'b0;
            gest_reg      <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_fire)
            begin
                event_reg <= event_next;
                armed_reg <= armed_next;
                gest_reg  <= gest_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            release_time_reg <= RELEASE_TIME_RST;
            pair_window_reg  <= PAIR_WINDOW_RST;
            long_time_reg    <= LONG_TIME_RST;
            chord_time_reg   <= CHORD_TIME_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // Writes to an index beyond the register list fall through.
            unique case (cfg_index)
                REG_RELEASE_TIME: release_time_reg <= cfg_data;
                REG_PAIR_WINDOW:  pair_window_reg  <= cfg_data;
                REG_LONG_TIME:    long_time_reg    <= cfg_data;
                REG_CHORD_TIME:   chord_time_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Decode one sample against the gesture state.
    always_comb
    begin
        gest_next  = gest_reg;
        armed_next = armed_reg;
        event_next = EV_NONE;
        was_first  = gest_reg.prev_first;
        was_second = gest_reg.prev_second;

        if (!armed_reg)
        begin
            // Wait for both buttons to stay released long enough.
            if (!s1_first_reg && !s1_second_reg)
            begin
                gest_next.release_timer = sat_add(gest_reg.release_timer, s1_elapsed_reg);
                if (time_ge(gest_next.release_timer, release_time_reg))
                begin
                    gest_next  = '0;
                    armed_next = 1'b1;
                end
            end
            else
            begin
                gest_next.release_timer = '0;
            end
        end
        else if (gest_reg.in_chord || gest_reg.suppressing)
        begin
            // A chord keeps timing its hold until it arms the sleep event.
            if (gest_reg.in_chord && s1_first_reg && s1_second_reg && !gest_reg.chord_armed)
            begin
                gest_next.hold_timer = sat_add(gest_reg.hold_timer, s1_elapsed_reg);
                if (time_ge(gest_next.hold_timer, chord_time_reg))
                begin
                    gest_next.chord_armed = 1'b1;
                end
            end
            if (s1_first_reg || s1_second_reg)
            begin
                gest_next.release_timer = '0;
            end
            else
            begin
                gest_next.release_timer = sat_add(gest_reg.release_timer, s1_elapsed_reg);
                if (time_ge(gest_next.release_timer, release_time_reg))
                begin
                    if (gest_next.chord_armed)
                    begin
                        event_next = EV_SLEEP;
                    end
                    gest_next = '0;
                end
            end
        end
        else
        begin
            gest_next.prev_first  = s1_first_reg;
            gest_next.prev_second = s1_second_reg;

            if (!was_first && !was_second && (s1_first_reg || s1_second_reg))
            begin
                // First press from idle; both at once starts a chord.
                gest_next.since_first_timer = sat_add('0, s1_elapsed_reg);
                gest_next.hold_timer        = sat_add('0, s1_elapsed_reg);
                if (s1_first_reg && s1_second_reg)
                begin
                    gest_next.in_chord = 1'b1;
                end
            end
            else if ((was_first != was_second) && s1_first_reg && s1_second_reg)
            begin
                // Second joins: chord if early and no long yet, else suppress.
                if (time_le(gest_reg.since_first_timer, pair_window_reg)
                    && !gest_reg.long_reported)
                begin
                    gest_next.in_chord   = 1'b1;
                    gest_next.hold_timer = sat_add('0, s1_elapsed_reg);
                end
                else
                begin
                    gest_next.suppressing = 1'b1;
                end
            end
            else if (s1_first_reg || s1_second_reg)
            begin
                gest_next.since_first_timer =
                    sat_add(gest_reg.since_first_timer, s1_elapsed_reg);
                gest_next.hold_timer = sat_add(gest_reg.hold_timer, s1_elapsed_reg);
                if (!gest_reg.long_reported && time_ge(gest_next.hold_timer, long_time_reg))
                begin
                    gest_next.long_reported = 1'b1;
                    event_next = s1_first_reg ? EV_FIRST_LONG : EV_SECOND_LONG;
                end
            end
            else if (was_first || was_second)
            begin
                // Release ends the gesture; a short press unless long was sent.
                if (!gest_reg.long_reported)
                begin
                    event_next = was_first ? EV_FIRST_SHORT : EV_SECOND_SHORT;
                end
                gest_next = '0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // While disarmed the decoder reports nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !armed_reg) |=> (event_code == EV_NONE))
    else $error("event reported while disarmed");

    // A gesture is never a chord and suppressed at the same time.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(gest_reg.in_chord && gest_reg.suppressing))
    else $error("chord and suppression both set");

    // Sleep can only follow a chord that had already been armed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !gest_reg.chord_armed) |=> (event_code != EV_SLEEP))
    else $error("sleep event without an armed chord");

    // At most one long press per gesture.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && gest_reg.long_reported)
        |=> (event_code != EV_FIRST_LONG) && (event_code != EV_SECOND_LONG))
    else $error("long press reported twice");
`endif

endmodule

`default_nettype wire

>>> sim/two_button_gesture_decoder_test.sv
// Self-checking testbench for two_button_gesture_decoder: drives button samples,
// predicts every event code and compares the results in order.
// Depends on tbgd_pkg and the two_button_gesture_decoder top level.
`timescale 1ns / 1ps

module two_button_gesture_decoder_test;

    import tbgd_pkg::*;

    // Saturation value of the millisecond timers.
    localparam logic [63:0] TIMER_FULL = (64'd1 << TIME_W) - 64'd1;

    // Indexes that the block does not decode; writes to them must be ignored.
    localparam cfg_index_t REG_PAST_END = 8'd4;
    localparam cfg_index_t REG_TOP_CODE = 8'd255;

    // Number of cycles the receiver refuses results during the pressure test.
    localparam int HOLD_OFF_CYCLES = 80;
    // Mismatch lines beyond this are counted but not printed.
    localparam int REPORT_LIMIT = 100;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_ALTERNATE
    } stall_mode_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_stall;
    logic       first_button  = 1'b0;
    logic       second_button = 1'b0;
    elapsed_t   elapsed       = '0;
    logic       out_valid;
    logic       out_stall     = 1'b0;
    logic [2:0] event_code;
    logic       cfg_valid     = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index     = '0;
    cfg_t       cfg_data      = '0;

    two_button_gesture_decoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .first_button  (first_button),
        .second_button (second_button),
        .elapsed       (elapsed),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_code    (event_code),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Gesture predictor. It mirrors the decoder's thresholds and gesture
    // state, and is stepped once for every sample beat that the block
    // accepts.
    // ------------------------------------------------------------------
    cfg_t  rearm_ms;
    cfg_t  window_ms;
    cfg_t  long_ms;
    cfg_t  sleep_hold_ms;

    logic  armed_now;
    logic  chord_on;
    logic  muted;
    logic  sleep_armed;
    logic  long_done;
    logic  last_first;
    logic  last_second;
    time_t quiet_ms;
    time_t pair_ms;
    time_t hold_ms;

    // Event codes still owed by the block, oldest first.
    event_t pending_events[$];

    int unsigned samples_sent = 0;
    int unsigned mismatches   = 0;
    int unsigned burst_left   = 0;
    logic        gaps_on      = 1'b1;
    logic        hold_toggle  = 1'b0;

    // A timer plus the elapsed time, held at the timer's full value.
    function automatic time_t timer_add(input time_t t, input elapsed_t el);
        logic [63:0] s;
        s = 64'(t) + 64'(el);
        if (s > TIMER_FULL)
        begin
            s = TIMER_FULL;
        end
        return time_t'(s);
    endfunction

    // Ending a gesture clears everything except the armed flag.
    function automatic void end_gesture();
        chord_on    = 1'b0;
        muted       = 1'b0;
        sleep_armed = 1'b0;
        long_done   = 1'b0;
        last_first  = 1'b0;
        last_second = 1'b0;
        quiet_ms    = '0;
        pair_ms     = '0;
        hold_ms     = '0;
    endfunction

    function automatic event_t predict_event(input logic a, input logic b,
                                             input elapsed_t el);
        logic was_a;
        logic was_b;
        logic sleep_due;

        // Until both buttons have been released long enough nothing is decoded.
        if (!armed_now)
        begin
            if (!a && !b)
            begin
                quiet_ms = timer_add(quiet_ms, el);
                if (quiet_ms >= rearm_ms)
                begin
                    end_gesture();
                    armed_now = 1'b1;
                end
            end
            else
            begin
                quiet_ms = '0;
            end
            return EV_NONE;
        end

        // A chord or a suppressed gesture runs until both buttons have been
        // released for the rearm time; only an armed chord reports anything.
        if (chord_on || muted)
        begin
            if (chord_on && a && b && !sleep_armed)
            begin
                hold_ms = timer_add(hold_ms, el);
                if (hold_ms >= sleep_hold_ms)
                begin
                    sleep_armed = 1'b1;
                end
            end
            if (a || b)
            begin
                quiet_ms = '0;
                return EV_NONE;
            end
            quiet_ms = timer_add(quiet_ms, el);
            if (quiet_ms < rearm_ms)
            begin
                return EV_NONE;
            end
            sleep_due = sleep_armed;
            end_gesture();
            return sleep_due ? EV_SLEEP : EV_NONE;
        end

        was_a       = last_first;
        was_b       = last_second;
        last_first  = a;
        last_second = b;

        // First press from idle; both at once starts a chord straight away.
        if (!was_a && !was_b && (a || b))
        begin
            pair_ms = timer_add('0, el);
            hold_ms = timer_add('0, el);
            if (a && b)
            begin
                chord_on = 1'b1;
            end
            return EV_NONE;
        end

        // Second button joins: chord in the window with no long yet, else muted.
        if ((was_a != was_b) && a && b)
        begin
            if (pair_ms <= window_ms && !long_done)
            begin
                chord_on = 1'b1;
                hold_ms  = timer_add('0, el);
            end
            else
            begin
                muted = 1'b1;
            end
            return EV_NONE;
        end

        // Continued hold, including a swap from one button to the other.
        if (a || b)
        begin
            pair_ms = timer_add(pair_ms, el);
            hold_ms = timer_add(hold_ms, el);
            if (!long_done && hold_ms >= long_ms)
            begin
                long_done = 1'b1;
                return a ? EV_FIRST_LONG : EV_SECOND_LONG;
            end
            return EV_NONE;
        end

        // Release after a single-button press.
        if (was_a || was_b)
        begin
            sleep_due = !long_done;
            end_gesture();
            if (sleep_due)
            begin
                return was_a ? EV_FIRST_SHORT : EV_SECOND_SHORT;
            end
        end
        return EV_NONE;
    endfunction

    // ------------------------------------------------------------------
    // Result checking. Every accepted result beat is matched against the
    // oldest pending event code.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        if (mismatches < REPORT_LIMIT)
        begin
            $display("mismatch at %0t ns: %s", $time, what);
        end
        mismatches++;
    endtask

    always @(posedge clk)
    begin : check_results
        event_t wanted;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_events.size() == 0)
            begin
                report_mismatch($sformatf("event_code %0d with no sample outstanding",
                                          event_code));
            end
            else
            begin
                wanted = pending_events.pop_front();
                if (event_code !== wanted)
                begin
                    report_mismatch($sformatf("event_code %0d, expected %0d (%s)",
                                              event_code, wanted, wanted.name()));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver. The stall pattern changes every so often between no stall,
    // light and heavy random stalling and strict alternation, so that the
    // stalls land on every phase of the pipeline. A flip of hold_toggle asks
    // for one long hold-off, counted here, during which no result is taken.
    // ------------------------------------------------------------------
    stall_mode_t stall_mode = STALL_NONE;
    int unsigned mode_left  = 0;
    int unsigned hold_left  = 0;
    logic        hold_seen  = 1'b0;

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_OFF_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= stall_mode_t'($urandom_range(0, 3));
                mode_left  <= $urandom_range(40, 200);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:     out_stall <= ~out_stall;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sender. Offers one sample beat, waits until it is taken, records the
    // predicted event and then, at the end of a burst, idles for a few
    // cycles. Bursts are usually short but now and then run long, giving
    // stretches with no idling at all.
    // ------------------------------------------------------------------
    task automatic send_sample(input logic a, input logic b, input elapsed_t el);
        int unsigned gap;
        first_button  <= a;
        second_button <= b;
        elapsed       <= el;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        pending_events.push_back(predict_event(a, b, el));
        samples_sent++;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 6);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 7);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // Waits until every outstanding sample has produced its result, so
    // that the thresholds may be changed.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // One register write beat. The valid is left high so that writes can
    // follow back to back; set_thresholds lowers it after the last one.
    task automatic write_register(input cfg_index_t idx, input cfg_t value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_RELEASE_TIME: rearm_ms      = value;
            REG_PAIR_WINDOW:  window_ms     = value;
            REG_LONG_TIME:    long_ms       = value;
            REG_CHORD_TIME:   sleep_hold_ms = value;
            default:          ;
        endcase
    endtask

    task automatic set_thresholds(input cfg_t rearm, input cfg_t window,
                                  input cfg_t long_hold, input cfg_t chord_hold);
        write_register(REG_RELEASE_TIME, rearm);
        write_register(REG_PAIR_WINDOW, window);
        write_register(REG_LONG_TIME, long_hold);
        write_register(REG_CHORD_TIME, chord_hold);
        cfg_valid <= 1'b0;
    endtask

    // Mostly small thresholds so that gestures complete within a few
    // samples, with both extremes and the odd full-range value.
    function automatic cfg_t pick_threshold();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return cfg_t'($urandom_range(0, 65535));
            default: return cfg_t'($urandom_range(1, 150));
        endcase
    endfunction

    function automatic elapsed_t pick_elapsed();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2, 3:    return elapsed_t'($urandom_range(0, 65535));
            default: return elapsed_t'($urandom_range(1, 40));
        endcase
    endfunction

    // One gesture with random timing: mostly well-formed presses, chords
    // and swaps, the rest noise or a chord that falls apart. Each one ends
    // with a release stretch of random length, which may or may not be
    // long enough to rearm.
    task automatic play_gesture();
        int unsigned n;
        int unsigned m;
        logic        one;
        n   = $urandom_range(1, 6);
        m   = $urandom_range(1, 4);
        one = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:
            begin
                repeat (n) send_sample(1'b0, 1'b0, pick_elapsed());
            end
            1, 2:
            begin
                repeat (n) send_sample(one, !one, pick_elapsed());
            end
            3:
            begin
                repeat (n) send_sample(1'b1, 1'b1, pick_elapsed());
            end
            4:
            begin
                repeat (m) send_sample(one, !one, pick_elapsed());
                repeat (n) send_sample(1'b1, 1'b1, pick_elapsed());
            end
            5:
            begin
                repeat (m) send_sample(one, !one, pick_elapsed());
                repeat (n) send_sample(!one, one, pick_elapsed());
            end
            6:
            begin
                repeat (n) send_sample(1'b1, 1'b1, pick_elapsed());
                repeat (m) send_sample(one, !one, pick_elapsed());
            end
            default:
            begin
                repeat (n)
                begin
                    send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                elapsed_t'($urandom_range(0, 65535)));
                end
            end
        endcase
        repeat ($urandom_range(1, 8)) send_sample(1'b0, 1'b0, pick_elapsed());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset thresholds: arming, both short and both long presses, a swap,
    // a chord pressed at once ending in sleep, a chord inside the pairing
    // window, a late second button, and a saturating elapsed value.
    task automatic test_default_gestures();
        send_sample(1'b1, 1'b0, 16'd5);     // pressed while disarmed
        send_sample(1'b0, 1'b0, 16'd60);
        send_sample(1'b0, 1'b0, 16'd40);    // reaches release_time, arms
        send_sample(1'b1, 1'b0, 16'd10);
        send_sample(1'b0, 1'b0, 16'd10);    // first short
        send_sample(1'b0, 1'b1, 16'd10);
        send_sample(1'b0, 1'b0, 16'd10);    // second short
        send_sample(1'b1, 1'b0, 16'd10);
        send_sample(1'b1, 1'b0, 16'd600);   // first long
        send_sample(1'b0, 1'b0, 16'd5);     // nothing after a long press
        send_sample(1'b1, 1'b0, 16'd10);
        send_sample(1'b0, 1'b1, 16'd300);   // swap continues the hold
        send_sample(1'b0, 1'b1, 16'd300);   // long names the button now down
        send_sample(1'b0, 1'b0, 16'd1);
        send_sample(1'b1, 1'b1, 16'd0);     // both at once
        send_sample(1'b1, 1'b1, 16'd2000);  // chord armed
        send_sample(1'b0, 1'b0, 16'hFFFF);  // sleep
        send_sample(1'b0, 1'b1, 16'd10);
        send_sample(1'b1, 1'b1, 16'd100);   // joins well inside the window
        send_sample(1'b0, 1'b0, 16'd100);
        send_sample(1'b1, 1'b0, 16'd10);
        send_sample(1'b1, 1'b0, 16'd95);
        send_sample(1'b1, 1'b1, 16'd10);    // too late, suppressed
        send_sample(1'b0, 1'b0, 16'd100);
    endtask

    // Every threshold at zero and then at its maximum, where only a
    // saturated timer can reach it; writes to undecoded indexes between.
    task automatic test_threshold_extremes();
        drain_results();
        set_thresholds('0, '0, '0, '0);
        send_sample(1'b1, 1'b0, 16'd0);
        send_sample(1'b1, 1'b0, 16'd0);     // zero long time fires on the next held sample
        send_sample(1'b0, 1'b0, 16'd0);
        send_sample(1'b1, 1'b1, 16'd0);
        send_sample(1'b1, 1'b1, 16'd0);
        send_sample(1'b0, 1'b0, 16'd0);     // sleep after a zero release time
        drain_results();
        write_register(REG_PAST_END, 16'h0001);
        write_register(REG_TOP_CODE, 16'h0002);
        set_thresholds('1, '1, '1, '1);
        send_sample(1'b0, 1'b1, 16'hFFFF);
        send_sample(1'b0, 1'b1, 16'd1);     // hold saturates, second long
        send_sample(1'b0, 1'b0, 16'd9);
    endtask

    // Random gestures over several random threshold settings.
    task automatic test_random_gestures();
        int unsigned phase_end;
        repeat (6)
        begin
            drain_results();
            set_thresholds(pick_threshold(), pick_threshold(),
                           pick_threshold(), pick_threshold());
            phase_end = samples_sent + 90;
            while (samples_sent < phase_end)
            begin
                play_gesture();
            end
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering beats without gaps, so the block fills and stalls its input.
    task automatic test_output_hold_off();
        int unsigned phase_end;
        drain_results();
        set_thresholds(16'd20, 16'd30, 16'd60, 16'd90);
        gaps_on     = 1'b0;
        hold_toggle <= ~hold_toggle;
        phase_end   = samples_sent + 50;
        while (samples_sent < phase_end)
        begin
            play_gesture();
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        rearm_ms      = RELEASE_TIME_RST;
        window_ms     = PAIR_WINDOW_RST;
        long_ms       = LONG_TIME_RST;
        sleep_hold_ms = CHORD_TIME_RST;
        armed_now     = 1'b0;
        end_gesture();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_gestures();
        test_threshold_extremes();
        test_random_gestures();
        test_output_hold_off();

        // One result per sample; the extra wait after the drain catches any
        // result the block should not have produced.
        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // Far beyond the slowest correct run of under a thousand samples.
    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
